// ----- src/bvt_pkg.sv -----
package bvt_pkg;

  typedef enum logic [2:0] {
    FN_APPEND = 3'd0,
    FN_READ   = 3'd1,
    FN_WRITE  = 3'd2,
    FN_DELETE = 3'd3,
    FN_SORT   = 3'd4
  } func_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_INDEX = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]         func;
    logic [5:0]         position;
    logic signed [31:0] element_in;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] element_out;
    logic [6:0]         fill_count;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_WAIT,
    S_RD_DONE,
    S_DEL_RD,
    S_DEL_WR,
    S_SRT_OUTER,
    S_SRT_CUR,
    S_SRT_CMP_RD,
    S_SRT_CMP,
    S_SRT_PLACE,
    S_DONE
  } state_t;

endpackage

// ----- src/bounded_vector_table.sv -----
// Channel   Handshake            Payload  Notes
// request   start / busy         req      transfer when start && !busy
// result    done (one cycle)     rsp      no backpressure
//
// Sequencing per request: append, write and unused codes go straight to the result;
// read waits on the registered memory read; delete shifts the entries above the
// position down one slot at a time through the one port and zeroes the last slot;
// sort is an ascending insertion sort, slowest for reverse-ordered input.
// Reset clears the count and the sequencer; the store holds no reset value.
// The result strobe lasts one cycle; the receiver cannot stall it.
module bounded_vector_table
  import bvt_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t req,
  output logic busy,
  output logic done,
  output rsp_t rsp
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  // compare width: holds both a full position and the count
  localparam int PW = (CW > 6) ? CW : 6;

  state_t state, state_next;

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_data;

  // Single memory port: one address, one write strobe per cycle.
  logic          we;
  logic [AW-1:0] addr;
  logic [31:0]   wdata;

  logic [CW-1:0] count;   // fill count
  logic [CW-1:0] idx_i;   // outer index / delete walker
  logic [CW-1:0] idx_j;   // insertion slot
  logic signed [31:0] cur;
  req_t          rq;
  logic [1:0]    status;
  logic [31:0]   rd_out;

  logic [PW-1:0] count_ext;
  assign count_ext = PW'(count);
  logic [PW-1:0] pos_ext;
  assign pos_ext = PW'(rq.position);
  logic in_range;
  assign in_range = pos_ext < count_ext;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rd_data <= mem[addr];
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (req.func)
            FN_READ:   state_next = S_RD_WAIT;
            FN_DELETE: state_next = S_DEL_RD;
            FN_SORT:   state_next = S_SRT_OUTER;
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_RD_WAIT:    state_next = S_RD_DONE;
      S_RD_DONE:    state_next = S_DONE;
      S_DEL_RD: begin
        if (!in_range || idx_i + 1'b1 >= count) state_next = S_DONE;
        else state_next = S_DEL_WR;
      end
      S_DEL_WR:     state_next = S_DEL_RD;
      S_SRT_OUTER:  state_next = (idx_i < count) ? S_SRT_CUR : S_DONE;
      S_SRT_CUR:    state_next = S_SRT_CMP_RD;
      S_SRT_CMP_RD: state_next = (idx_j == '0) ? S_SRT_PLACE : S_SRT_CMP;
      S_SRT_CMP: begin
        // rd_data = element j-1; shift it up when greater than cur
        if (rd_data > cur) state_next = S_SRT_CMP_RD;
        else state_next = S_SRT_PLACE;
      end
      S_SRT_PLACE:  state_next = S_SRT_OUTER;
      S_DONE:       state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  // Memory port control
  always_comb begin
    we    = 1'b0;
    addr  = idx_i[AW-1:0];
    wdata = rd_data;
    case (state)
      S_IDLE: begin
        addr  = count[AW-1:0];
        wdata = req.element_in;
        if (start && req.func == FN_APPEND && count < CW'(DEPTH)) we = 1'b1;
        if (start && req.func == FN_WRITE && PW'(req.position) < count_ext) begin
          addr = AW'(req.position);
          we   = 1'b1;
        end
        if (start && req.func == FN_READ) addr = AW'(req.position);
      end
      S_RD_WAIT: addr = AW'(rq.position);
      S_DEL_RD: begin
        // read i+1, or zero the last slot when the walk ends
        addr = AW'(idx_i + 1'b1);
        if (in_range && idx_i + 1'b1 >= count) begin
          addr  = idx_i[AW-1:0];
          wdata = '0;
          we    = 1'b1;
        end
      end
      S_DEL_WR: begin
        addr = idx_i[AW-1:0];
        we   = 1'b1;
      end
      S_SRT_OUTER:  addr = idx_i[AW-1:0];
      S_SRT_CMP_RD: addr = AW'(idx_j - 1'b1);
      S_SRT_CMP: begin
        addr = idx_j[AW-1:0];
        we   = rd_data > cur;
      end
      S_SRT_PLACE: begin
        addr  = idx_j[AW-1:0];
        wdata = cur;
        we    = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: if (start) begin
          rq     <= req;
          status <= ST_OK;
          rd_out <= '0;
          idx_i  <= (req.func == FN_SORT) ? CW'(1) : CW'(req.position);
          case (req.func)
            FN_APPEND: begin
              if (count < CW'(DEPTH)) count <= count + 1'b1;
              else status <= ST_FULL;
            end
            FN_READ, FN_WRITE, FN_DELETE:
              if (PW'(req.position) >= count_ext) status <= ST_INDEX;
            default: ;
          endcase
        end
        S_RD_DONE: if (in_range) rd_out <= rd_data;
        S_DEL_RD: if (in_range && idx_i + 1'b1 >= count) count <= count - 1'b1;
        S_DEL_WR:  idx_i <= idx_i + 1'b1;
        S_SRT_OUTER: idx_j <= idx_i;
        S_SRT_CUR:   cur <= rd_data;
        S_SRT_CMP:   if (rd_data > cur) idx_j <= idx_j - 1'b1;
        S_SRT_PLACE: idx_i <= idx_i + 1'b1;
        default: ;
      endcase
    end
  end

  // Outputs
  always_comb begin
    busy = (state != S_IDLE);
    done = (state == S_DONE);
    rsp.status      = status;
    rsp.element_out = rd_out;
    rsp.fill_count  = 7'(count);
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("count above depth");
  a_done_once: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("double result strobe");
  a_busy_done: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result while idle");

endmodule
